FILE: rtl/core/assert_macros.svh
// Assertion helpers for the core RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define MVT_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

`define MVT_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`else

`define MVT_ASSERT(lbl, clk, rst, prop)
`define MVT_ASSERT_RST(lbl, clk, prop)

`endif

`endif

FILE: rtl/core/mvt_pkg.sv
package mvt_pkg;

  localparam int COEFF_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  localparam int COMP_WIDTH = 32;
  localparam int DIM        = 4;
  localparam int ELEMS      = DIM * DIM;
  localparam int REG_COUNT  = ELEMS / 2;
  localparam int REG_WIDTH  = 64;
  localparam int HALF_WIDTH = REG_WIDTH / 2;
  localparam int ADDR_WIDTH = 6;
  localparam int IDX_LSB    = 3;
  localparam int IDX_WIDTH  = $clog2(REG_COUNT);
  localparam int DATA_WIDTH = DIM * COMP_WIDTH;

  typedef logic signed [COMP_WIDTH-1:0] comp_t;
  typedef logic [REG_WIDTH-1:0] reg_word_t;

  // identity matrix: 1.0 on the diagonal
  localparam reg_word_t REG_RESET [REG_COUNT] = '{
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000
  };

endpackage

FILE: rtl/core/mat4_vec4_transform.sv
// 4x4 matrix times 4-vector transform in signed fixed point. One vector is taken per
// cycle and passes through four register stages: a multiplier stage forming all
// sixteen products, two adder stages summing each row exactly, and a shift and
// saturate stage feeding the output register. Stalls propagate back from m_tready
// through the stage enables, so the input stays ready while any stage has room.
// The matrix is written through the register port at byte address 8*k (elements 2k in
// bits 31..0 and 2k+1 in bits 63..32, column-major) and resets to identity; write it
// only while no item is in flight.
`include "assert_macros.svh"

module mat4_vec4_transform #(
  parameter int COEFF_WIDTH = mvt_pkg::COEFF_WIDTH_DEF,
  parameter int FRAC_BITS   = mvt_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [mvt_pkg::ADDR_WIDTH-1:0] paddr,
  input  logic [mvt_pkg::REG_WIDTH-1:0] pwdata,
  output logic [mvt_pkg::REG_WIDTH-1:0] prdata,
  output logic pready,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [mvt_pkg::DATA_WIDTH-1:0] s_tdata,  // in_x, in_y, in_z, in_w
  output logic m_tvalid,
  input  logic m_tready,
  output logic [mvt_pkg::DATA_WIDTH-1:0] m_tdata,  // out_x, out_y, out_z, out_w
  output logic m_tuser                             // overflow
);

  localparam int PW = COEFF_WIDTH + mvt_pkg::COMP_WIDTH;
  localparam int SW = PW + 2;

  mvt_pkg::reg_word_t coeff_reg [mvt_pkg::REG_COUNT];
  logic [mvt_pkg::IDX_WIDTH-1:0] reg_idx;
  logic signed [COEFF_WIDTH-1:0] coeff [mvt_pkg::ELEMS];
  mvt_pkg::comp_t vec [mvt_pkg::DIM];
  mvt_pkg::comp_t res [mvt_pkg::DIM];

  logic mul_valid;
  logic mul_ready;
  logic acc_valid;
  logic acc_ready;
  logic signed [PW-1:0] prod [mvt_pkg::DIM][mvt_pkg::DIM];
  logic signed [SW-1:0] sum [mvt_pkg::DIM];

  assign reg_idx = paddr[mvt_pkg::IDX_LSB +: mvt_pkg::IDX_WIDTH];
  assign pready  = 1'b1;
  assign prdata  = coeff_reg[reg_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      coeff_reg <= mvt_pkg::REG_RESET;
    end else if (psel && penable && pwrite) begin
      coeff_reg[reg_idx] <= pwdata;
    end
  end

  for (genvar r = 0; r < mvt_pkg::REG_COUNT; r++) begin : g_reg
    for (genvar h = 0; h < 2; h++) begin : g_half
      assign coeff[2*r+h] = coeff_reg[r][h*mvt_pkg::HALF_WIDTH +: COEFF_WIDTH];
    end
  end

  always_comb begin
    for (int j = 0; j < mvt_pkg::DIM; j++) begin
      vec[j] = s_tdata[j*mvt_pkg::COMP_WIDTH +: mvt_pkg::COMP_WIDTH];
    end
  end

  always_comb begin
    for (int i = 0; i < mvt_pkg::DIM; i++) begin
      m_tdata[i*mvt_pkg::COMP_WIDTH +: mvt_pkg::COMP_WIDTH] = res[i];
    end
  end

  mvt_mul #(
    .COEFF_WIDTH(COEFF_WIDTH),
    .PW(PW)
  ) u_mul (
    .clk(clk),
    .rst(rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .vec(vec),
    .coeff(coeff),
    .out_valid(mul_valid),
    .out_ready(mul_ready),
    .prod(prod)
  );

  mvt_acc #(
    .PW(PW)
  ) u_acc (
    .clk(clk),
    .rst(rst),
    .in_valid(mul_valid),
    .in_ready(mul_ready),
    .prod(prod),
    .out_valid(acc_valid),
    .out_ready(acc_ready),
    .sum(sum)
  );

  mvt_sat #(
    .SW(SW),
    .FRAC_BITS(FRAC_BITS)
  ) u_sat (
    .clk(clk),
    .rst(rst),
    .in_valid(acc_valid),
    .in_ready(acc_ready),
    .sum(sum),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .res(res),
    .ovf(m_tuser)
  );

  `MVT_ASSERT_RST(a_reset_empty, clk, rst |=> !m_tvalid)
  `MVT_ASSERT(a_ready_follows, clk, rst, m_tready |-> s_tready)
  `MVT_ASSERT(a_ovf_clamped, clk, rst,
    (m_tvalid && m_tuser) |->
      (m_tdata[31:0] == 32'h7FFF_FFFF || m_tdata[31:0] == 32'h8000_0000 ||
       m_tdata[63:32] == 32'h7FFF_FFFF || m_tdata[63:32] == 32'h8000_0000 ||
       m_tdata[95:64] == 32'h7FFF_FFFF || m_tdata[95:64] == 32'h8000_0000 ||
       m_tdata[127:96] == 32'h7FFF_FFFF || m_tdata[127:96] == 32'h8000_0000))

endmodule

FILE: rtl/core/mvt_mul.sv
module mvt_mul #(
  parameter int COEFF_WIDTH = mvt_pkg::COEFF_WIDTH_DEF,
  parameter int PW = COEFF_WIDTH + mvt_pkg::COMP_WIDTH
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  mvt_pkg::comp_t vec [mvt_pkg::DIM],
  input  logic signed [COEFF_WIDTH-1:0] coeff [mvt_pkg::ELEMS],
  output logic out_valid,
  input  logic out_ready,
  output logic signed [PW-1:0] prod [mvt_pkg::DIM][mvt_pkg::DIM]
);

  logic en;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // prod[i][j] = m[4j+i] * v[j]
  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      for (int i = 0; i < mvt_pkg::DIM; i++) begin
        for (int j = 0; j < mvt_pkg::DIM; j++) begin
          prod[i][j] <= coeff[mvt_pkg::DIM * j + i] * vec[j];
        end
      end
    end
  end

endmodule

FILE: rtl/core/mvt_acc.sv
module mvt_acc #(
  parameter int PW = mvt_pkg::COEFF_WIDTH_DEF + mvt_pkg::COMP_WIDTH
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [PW-1:0] prod [mvt_pkg::DIM][mvt_pkg::DIM],
  output logic out_valid,
  input  logic out_ready,
  output logic signed [PW+1:0] sum [mvt_pkg::DIM]
);

  logic pair_valid;
  logic pair_en;
  logic sum_en;
  logic signed [PW:0] pair [mvt_pkg::DIM][2];

  assign sum_en   = !out_valid || out_ready;
  assign pair_en  = !pair_valid || sum_en;
  assign in_ready = pair_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (pair_en) begin
        pair_valid <= in_valid;
      end
      if (sum_en) begin
        out_valid <= pair_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pair_en && in_valid) begin
      for (int i = 0; i < mvt_pkg::DIM; i++) begin
        pair[i][0] <= (PW+1)'(prod[i][0]) + (PW+1)'(prod[i][1]);
        pair[i][1] <= (PW+1)'(prod[i][2]) + (PW+1)'(prod[i][3]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sum_en && pair_valid) begin
      for (int i = 0; i < mvt_pkg::DIM; i++) begin
        sum[i] <= (PW+2)'(pair[i][0]) + (PW+2)'(pair[i][1]);
      end
    end
  end

endmodule

FILE: rtl/core/mvt_sat.sv
module mvt_sat #(
  parameter int SW = mvt_pkg::COEFF_WIDTH_DEF + mvt_pkg::COMP_WIDTH + 2,
  parameter int FRAC_BITS = mvt_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [SW-1:0] sum [mvt_pkg::DIM],
  output logic out_valid,
  input  logic out_ready,
  output mvt_pkg::comp_t res [mvt_pkg::DIM],
  output logic ovf
);

  localparam int SHW = SW - FRAC_BITS;
  localparam int CW  = (SHW > mvt_pkg::COMP_WIDTH + 1) ? SHW : mvt_pkg::COMP_WIDTH + 1;
  localparam logic signed [CW-1:0] MAX_V =
    {{(CW-mvt_pkg::COMP_WIDTH+1){1'b0}}, {(mvt_pkg::COMP_WIDTH-1){1'b1}}};
  localparam logic signed [CW-1:0] MIN_V =
    {{(CW-mvt_pkg::COMP_WIDTH+1){1'b1}}, {(mvt_pkg::COMP_WIDTH-1){1'b0}}};

  logic en;
  logic signed [SHW-1:0] shifted [mvt_pkg::DIM];
  logic signed [CW-1:0] wide [mvt_pkg::DIM];
  mvt_pkg::comp_t res_next [mvt_pkg::DIM];
  logic [mvt_pkg::DIM-1:0] sat;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // floor shift, then clamp to the signed component range
  always_comb begin
    for (int i = 0; i < mvt_pkg::DIM; i++) begin
      shifted[i] = sum[i][SW-1:FRAC_BITS];
      wide[i]    = CW'(shifted[i]);
      if (wide[i] > MAX_V) begin
        res_next[i] = MAX_V[mvt_pkg::COMP_WIDTH-1:0];
        sat[i]      = 1'b1;
      end else if (wide[i] < MIN_V) begin
        res_next[i] = MIN_V[mvt_pkg::COMP_WIDTH-1:0];
        sat[i]      = 1'b1;
      end else begin
        res_next[i] = wide[i][mvt_pkg::COMP_WIDTH-1:0];
        sat[i]      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      res <= res_next;
      ovf <= |sat;
    end
  end

endmodule
